FILE: rtl/core/smlr_pkg.sv
// ----------------------------------------------------------------------------
// smlr_pkg
// Shared types and constants for the stereo mix / 441:160 linear resampler.
// ----------------------------------------------------------------------------
package smlr_pkg;

    localparam int SAMPLE_W = 16;

    // 44100/16000 reduced
    localparam int STEP_NUM = 441;
    localparam int STEP_DEN = 160;
    localparam int REM_W    = 8;
    localparam int WT_W     = REM_W + 1;
    localparam int PSUM_W   = 10;

    // interpolation numerator and its magnitude (|num| <= 2^(W-1) * 160)
    localparam int NUM_W    = SAMPLE_W + 9;
    localparam int MAG_W    = SAMPLE_W + 7;

    // num / 160 = (num >> 5) / 5, the /5 done by reciprocal multiply
    localparam int DIV_SHIFT = 5;
    localparam int DIV_ODD   = 5;
    localparam int QIN_W     = MAG_W - DIV_SHIFT;
    localparam int DIV_K     = QIN_W + 3;
    localparam int RECIP_W   = DIV_K - 2;
    localparam longint unsigned RECIP = ((64'd1 << DIV_K) + DIV_ODD - 1) / DIV_ODD;
    localparam int PROD_W    = QIN_W + RECIP_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       block_last;
    } smlr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono_out;
        logic                       run_last;
        logic                       from_block_end;
    } smlr_out_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono;
        logic                       block_last;
    } smlr_mix_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic                    from_block_end;
    } smlr_rel_t;

endpackage

FILE: rtl/core/smlr_mix.sv
// ----------------------------------------------------------------------------
// smlr_mix
// Input register: accepts a stereo frame and stores its mono mix,
// (left + right) / 2 truncated toward zero.
// ----------------------------------------------------------------------------
module smlr_mix
    import smlr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  smlr_in_t  s_item,
    input  logic      take,
    output logic      mix_valid,
    output smlr_mix_t mix_item
);

    logic                     valid_reg;
    logic                     valid_next;
    smlr_mix_t                item_reg;
    smlr_mix_t                item_next;
    logic                     load;
    logic signed [SAMPLE_W:0] pair_sum;
    logic signed [SAMPLE_W:0] pair_adj;

    assign s_ready   = !valid_reg || take;
    assign load      = s_valid && s_ready;
    assign mix_valid = valid_reg;
    assign mix_item  = item_reg;

    always_comb begin
        pair_sum = {s_item.left_sample[SAMPLE_W-1], s_item.left_sample}
                 + {s_item.right_sample[SAMPLE_W-1], s_item.right_sample};
        // bias negative sums by one so the shift truncates toward zero
        pair_adj = pair_sum + $signed({{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]});
        item_next.mono       = SAMPLE_W'(pair_adj >>> 1);
        item_next.block_last = s_item.block_last;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/core/smlr_phase.sv
// ----------------------------------------------------------------------------
// smlr_phase
// Resampler phase tracking: computes the interpolation numerator for each
// output position, holds it until the frame count proves it lies inside the
// block, and restarts all phase state after the block's final frame.
// ----------------------------------------------------------------------------
module smlr_phase
    import smlr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      mix_valid,
    input  smlr_mix_t mix_item,
    output logic      take,
    input  logic      dn_ready,
    output logic      rel_valid,
    output smlr_rel_t rel_item
);

    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [1:0]                 fuo_reg, fuo_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic                       held_valid_reg, held_valid_next;
    logic signed [NUM_W-1:0]    held_num_reg, held_num_next;
    logic [1:0]                 wait_reg, wait_next;

    logic [1:0]                 wait_dec;
    logic                       release_now;
    logic [PSUM_W-1:0]          phase_sum;
    logic                       wide_step;
    logic [WT_W-1:0]            wt_prev;
    logic signed [NUM_W-1:0]    blend;

    assign take = mix_valid && dn_ready;

    always_comb begin
        wait_dec    = (wait_reg != 2'd0) ? wait_reg - 2'd1 : 2'd0;
        release_now = held_valid_reg && (wait_dec == 2'd0);

        rel_valid               = take && release_now;
        rel_item.num            = held_num_reg;
        rel_item.from_block_end = mix_item.block_last;

        phase_sum = PSUM_W'(rem_reg) + PSUM_W'(STEP_NUM);
        wide_step = phase_sum >= PSUM_W'(3 * STEP_DEN);
        wt_prev   = WT_W'(STEP_DEN) - {1'b0, rem_reg};
        blend     = NUM_W'(prev_reg) * NUM_W'($signed({1'b0, wt_prev}))
                  + NUM_W'(mix_item.mono) * NUM_W'($signed({1'b0, rem_reg}));

        prev_next       = prev_reg;
        fuo_next        = fuo_reg;
        rem_next        = rem_reg;
        held_valid_next = held_valid_reg;
        held_num_next   = held_num_reg;
        wait_next       = wait_reg;

        if (take) begin
            if (held_valid_reg) begin
                wait_next = wait_dec;
            end
            if (release_now) begin
                held_valid_next = 1'b0;
            end

            if (fuo_reg == 2'd0) begin
                held_num_next   = blend;
                held_valid_next = 1'b1;
                // release needs ceil((rem+441)/160) - 2 frames past the index
                wait_next       = (phase_sum > PSUM_W'(3 * STEP_DEN)) ? 2'd2 : 2'd1;
                rem_next        = wide_step ? REM_W'(phase_sum - PSUM_W'(3 * STEP_DEN))
                                            : REM_W'(phase_sum - PSUM_W'(2 * STEP_DEN));
                fuo_next        = wide_step ? 2'd2 : 2'd1;
            end else begin
                fuo_next = fuo_reg - 2'd1;
            end

            prev_next = mix_item.mono;

            if (mix_item.block_last) begin
                prev_next       = '0;
                fuo_next        = 2'd1;
                rem_next        = '0;
                held_valid_next = 1'b0;
                wait_next       = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            fuo_reg        <= 2'd1;
            rem_reg        <= '0;
            held_valid_reg <= 1'b0;
            wait_reg       <= 2'd0;
        end else begin
            prev_reg       <= prev_next;
            fuo_reg        <= fuo_next;
            rem_reg        <= rem_next;
            held_valid_reg <= held_valid_next;
            wait_reg       <= wait_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_num_reg <= held_num_next;
    end

endmodule

FILE: rtl/core/smlr_div160.sv
// ----------------------------------------------------------------------------
// smlr_div160
// Two-stage signed divide by 160, truncating toward zero: magnitude and
// reciprocal multiply, then shift, sign restore and result register.
// ----------------------------------------------------------------------------
module smlr_div160
    import smlr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      rel_valid,
    input  smlr_rel_t rel_item,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output smlr_out_t m_item
);

    logic                a_valid_reg, a_valid_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                neg_reg;
    logic                end_reg;
    logic                out_valid_reg, out_valid_next;
    smlr_out_t           out_reg, out_next;

    logic                en_a;
    logic                en_b;
    logic [NUM_W-1:0]    mag;
    logic [QIN_W-1:0]    qin;
    logic [SAMPLE_W-1:0] quot;

    assign en_b     = !out_valid_reg || m_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    always_comb begin
        mag       = rel_item.num[NUM_W-1] ? NUM_W'(-rel_item.num) : NUM_W'(rel_item.num);
        qin       = mag[MAG_W-1:DIV_SHIFT];
        prod_next = PROD_W'(qin) * PROD_W'(RECIP);

        quot                    = prod_reg[PROD_W-1:DIV_K];
        out_next.mono_out       = neg_reg ? $signed(-quot) : $signed(quot);
        out_next.run_last       = 1'b1;
        out_next.from_block_end = end_reg;

        a_valid_next   = en_a ? rel_valid : a_valid_reg;
        out_valid_next = en_b ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rel_valid && en_a) begin
            prod_reg <= prod_next;
            neg_reg  <= rel_item.num[NUM_W-1];
            end_reg  <= rel_item.from_block_end;
        end
        if (a_valid_reg && en_b) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/core/stereo_mix_linear_resampler_unit.sv
// ----------------------------------------------------------------------------
// stereo_mix_linear_resampler_unit
// Stereo-to-mono mix with 441:160 linear-interpolation downsampling.
// A result released by the phase stage passes the divide and result registers.
// Throughput: one frame per cycle unless m_ready stalls, at most one result
// per frame; the four-register chain (input, phase, divide, result) sets this.
// Reset (aresetn low, synchronous) empties the pipeline and restarts the phase.
// ----------------------------------------------------------------------------
module stereo_mix_linear_resampler_unit
    import smlr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  smlr_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output smlr_out_t m_item
);

    logic      mix_valid;
    smlr_mix_t mix_item;
    logic      take;
    logic      div_ready;
    logic      rel_valid;
    smlr_rel_t rel_item;

    smlr_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .take      (take),
        .mix_valid (mix_valid),
        .mix_item  (mix_item)
    );

    smlr_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mix_valid (mix_valid),
        .mix_item  (mix_item),
        .take      (take),
        .dn_ready  (div_ready),
        .rel_valid (rel_valid),
        .rel_item  (rel_item)
    );

    smlr_div160 u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rel_valid (rel_valid),
        .rel_item  (rel_item),
        .in_ready  (div_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
